/* sv/pdnp_pkg.sv */
// Package for the packed date next/previous stepper.
// Holds the field widths, reciprocal constants, month table and the types shared by
// pdnp_split, pdnp_step, pdnp_pack and packed_date_next_prev_top.
package pdnp_pkg;

	// Field widths
	localparam int DATE_W  = 27;
	localparam int YEAR_W  = 14;   // v / 10000 stays below 2^14
	localparam int YEARX_W = 15;   // stepped year, two's complement (-1 possible)
	localparam int REM_W   = 14;   // v % 10000
	localparam int MON_W   = 7;
	localparam int DAY_W   = 7;
	localparam int LEN_W   = 5;

	// Step direction codes
	localparam logic FUNC_NEXT = 1'b0;
	localparam logic FUNC_PREV = 1'b1;

	// Reciprocal for v / 10000 over 27-bit v: q = (v * RECIP_10K) >> SHIFT_10K
	localparam logic [27:0] RECIP_10K = 28'd219902326;
	localparam int          SHIFT_10K = 41;
	// Reciprocal for x / 100 over 14-bit x: q = (x * RECIP_100) >> SHIFT_100
	localparam logic [14:0] RECIP_100 = 15'd20972;
	localparam int          SHIFT_100 = 21;

	localparam logic [13:0]      K_10000 = 14'd10000;
	localparam logic [6:0]       K_100   = 7'd100;
	localparam logic [MON_W-1:0] MON_DEC = 7'd12;
	localparam logic [MON_W-1:0] MON_WRAP = 7'd13;
	localparam logic [MON_W-1:0] MON_JAN = 7'd1;
	localparam logic [MON_W-1:0] MON_FEB = 7'd2;
	localparam logic [DAY_W-1:0] DAY_LAST_DEC = 7'd31;
	localparam logic [LEN_W-1:0] LEN_LONG = 5'd31;
	localparam logic [LEN_W-1:0] LEN_FEB_LEAP = 5'd29;

	// Split date, after the divide stages
	typedef struct packed {
		logic              func;
		logic [YEAR_W-1:0] yy;
		logic [MON_W-1:0]  mm;
		logic [REM_W-1:0]  rem;    // v % 10000, day still folded in
		logic              leap;
	} pdnp_split_t;

	// Stepped date, ready to repack
	typedef struct packed {
		logic [YEARX_W-1:0] yy;
		logic [MON_W-1:0]   mm;
		logic [DAY_W-1:0]   dd;
	} pdnp_ymd_t;

	// Per-stage load enables
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic out;
	} pdnp_en_t;

	// Days in a month; month zero counts as zero days, above twelve as 31
	function automatic logic [LEN_W-1:0] days_in(input logic [MON_W-1:0] mm, input logic leap);
		logic [LEN_W-1:0] len;
		begin
			if (mm > MON_DEC) begin
				len = LEN_LONG;
			end else begin
				unique case (mm[3:0])
					4'd0:  len = 5'd0;
					4'd1:  len = 5'd31;
					4'd2:  len = leap ? LEN_FEB_LEAP : 5'd28;
					4'd3:  len = 5'd31;
					4'd4:  len = 5'd30;
					4'd5:  len = 5'd31;
					4'd6:  len = 5'd30;
					4'd7:  len = 5'd31;
					4'd8:  len = 5'd31;
					4'd9:  len = 5'd30;
					4'd10: len = 5'd31;
					4'd11: len = 5'd30;
					4'd12: len = 5'd31;
					default: len = 5'd0;
				endcase
			end
			return len;
		end
	endfunction

endpackage

/* sv/pdnp_split.sv */
// Input register and divide stages: splits packed YYYYMMDD into year, month and
// remainder, and works out the leap flag. Depends on pdnp_pkg.
module pdnp_split import pdnp_pkg::*; (
	input  logic              clk,
	input  pdnp_en_t          en,
	input  logic              func,
	input  logic [DATE_W-1:0] date_in,
	output pdnp_split_t       split
);

	logic              func_s1;
	logic [DATE_W-1:0] date_s1;

	logic              func_s2;
	logic [YEAR_W-1:0] yy_s2;
	logic [REM_W-1:0]  lo_s2;

	logic              func_s3;
	logic [YEAR_W-1:0] yy_s3;
	logic [REM_W-1:0]  rem_s3;
	logic [7:0]        yh_s3;

	logic              func_s4;
	logic [YEAR_W-1:0] yy_s4;
	logic [REM_W-1:0]  rem_s4;
	logic [MON_W-1:0]  mm_s4;
	logic              leap_s4;

	logic [54:0] yq_prod;
	logic [27:0] ym_prod;
	logic [28:0] yh_prod;
	logic [28:0] mq_prod;
	logic [14:0] yc_prod;
	logic        div100;
	logic        leap;

	// Capture the input beat
	always_ff @(posedge clk) begin
		if (en.s1) begin
			func_s1 <= func;
			date_s1 <= date_in;
		end
	end

	// Year by reciprocal multiply
	assign yq_prod = {27'd0, date_s1} * {27'd0, RECIP_10K};

	always_ff @(posedge clk) begin
		if (en.s2) begin
			func_s2 <= func_s1;
			yy_s2   <= yq_prod[SHIFT_10K +: YEAR_W];
			lo_s2   <= date_s1[REM_W-1:0];
		end
	end

	// Remainder mod 2^14 is exact, since it stays below 10000; year / 100 for leap test
	assign ym_prod = {14'd0, yy_s2} * {14'd0, K_10000};
	assign yh_prod = {15'd0, yy_s2} * {14'd0, RECIP_100};

	always_ff @(posedge clk) begin
		if (en.s3) begin
			func_s3 <= func_s2;
			yy_s3   <= yy_s2;
			rem_s3  <= lo_s2 - ym_prod[REM_W-1:0];
			yh_s3   <= yh_prod[SHIFT_100 +: 8];
		end
	end

	// Month by reciprocal multiply; leap: by 4 and not by 100, or by 400
	assign mq_prod = {15'd0, rem_s3} * {14'd0, RECIP_100};
	assign yc_prod = {7'd0, yh_s3} * {8'd0, K_100};
	assign div100  = (yc_prod == {1'b0, yy_s3});
	assign leap    = ((yy_s3[1:0] == 2'd0) && !div100) || (div100 && (yh_s3[1:0] == 2'd0));

	always_ff @(posedge clk) begin
		if (en.s4) begin
			func_s4 <= func_s3;
			yy_s4   <= yy_s3;
			rem_s4  <= rem_s3;
			mm_s4   <= mq_prod[SHIFT_100 +: MON_W];
			leap_s4 <= leap;
		end
	end

	assign split.func = func_s4;
	assign split.yy   = yy_s4;
	assign split.mm   = mm_s4;
	assign split.rem  = rem_s4;
	assign split.leap = leap_s4;

endmodule

/* sv/pdnp_step.sv */
// Day step stage: recovers the day and rolls day, month and year forward or back.
// Depends on pdnp_pkg.
module pdnp_step import pdnp_pkg::*; (
	input  logic        clk,
	input  pdnp_en_t    en,
	input  pdnp_split_t split,
	output pdnp_ymd_t   ymd
);

	logic [13:0]        mc_prod;
	logic [DAY_W-1:0]   dd;
	logic [LEN_W-1:0]   len_cur;
	logic [LEN_W-1:0]   len_prv;
	logic [MON_W-1:0]   mm_dec;
	logic [DAY_W:0]     dd_inc;
	logic [YEARX_W-1:0] yy_ext;
	logic [YEARX_W-1:0] yy_n;
	logic [MON_W-1:0]   mm_n;
	logic [DAY_W-1:0]   dd_n;
	pdnp_ymd_t          ymd_s5;

	// Day is what is left after the month hundreds; exact mod 2^7
	assign mc_prod = {7'd0, split.mm} * {7'd0, K_100};
	assign dd      = split.rem[DAY_W-1:0] - mc_prod[DAY_W-1:0];

	assign mm_dec  = split.mm - MON_JAN;
	assign len_cur = days_in(split.mm, split.leap);
	assign len_prv = days_in(mm_dec, split.leap);
	assign dd_inc  = {1'b0, dd} + 8'd1;
	assign yy_ext  = {1'b0, split.yy};

	// Roll forward or back
	always_comb begin
		yy_n = yy_ext;
		mm_n = split.mm;
		dd_n = dd;
		if (split.func == FUNC_NEXT) begin
			if (dd_inc > {3'd0, len_cur}) begin
				dd_n = 7'd1;
				mm_n = split.mm + MON_JAN;
			end else begin
				dd_n = dd_inc[DAY_W-1:0];
			end
			if (mm_n == MON_WRAP) begin
				mm_n = MON_JAN;
				yy_n = yy_ext + 15'd1;
			end
		end else begin
			priority if (((split.mm == MON_JAN) && (dd == 7'd1)) ||
					((split.mm == 7'd0) && (dd <= 7'd1))) begin
				yy_n = yy_ext - 15'd1;
				mm_n = MON_DEC;
				dd_n = DAY_LAST_DEC;
			end else if (dd > 7'd1) begin
				dd_n = dd - 7'd1;
			end else begin
				mm_n = mm_dec;
				dd_n = {2'd0, len_prv};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			ymd_s5.yy <= yy_n;
			ymd_s5.mm <= mm_n;
			ymd_s5.dd <= dd_n;
		end
	end

	assign ymd = ymd_s5;

endmodule

/* sv/pdnp_pack.sv */
// Repack stage: forms year*10000 + month*100 + day modulo 2^27 into the output register.
// Depends on pdnp_pkg.
module pdnp_pack import pdnp_pkg::*; (
	input  logic              clk,
	input  pdnp_en_t          en,
	input  pdnp_ymd_t         ymd,
	output logic [DATE_W-1:0] date_out
);

	logic [DATE_W-1:0] yy_sx;
	logic [40:0]       y_prod;
	logic [13:0]       m_prod;
	logic [DATE_W-1:0] packed_sum;
	logic [DATE_W-1:0] date_out_q;

	// Sign-extend the year so a year of -1 wraps correctly
	assign yy_sx      = {{(DATE_W-YEARX_W){ymd.yy[YEARX_W-1]}}, ymd.yy};
	assign y_prod     = {14'd0, yy_sx} * {27'd0, K_10000};
	assign m_prod     = {7'd0, ymd.mm} * {7'd0, K_100};
	assign packed_sum = y_prod[DATE_W-1:0] + {13'd0, m_prod} + {20'd0, ymd.dd};

	// Hold the result beat
	always_ff @(posedge clk) begin
		if (en.out) begin
			date_out_q <= packed_sum;
		end
	end

	assign date_out = date_out_q;

endmodule

/* sv/packed_date_next_prev_top.sv */
// Top level of the packed date next/previous stepper: handshake and stage valids.
// Depends on pdnp_pkg, pdnp_split, pdnp_step and pdnp_pack.
//
//  channel | signals                           | direction
//  --------+-----------------------------------+-----------
//  in      | in_valid, in_stall, func, date_in | into block
//  out     | out_valid, out_stall, date_out    | out of block
//
// Six register stages: input, year divide, remainder, month and leap, day step, repack.
// One beat is accepted every cycle while in_stall is low.
// Each stage loads when empty or when the stage after it moves, so bubbles close up
// and input beats keep flowing while a result waits on out_stall, until all six
// stages hold a beat.
// arst_n clears the stage valids only; the datapath registers carry no reset.
module packed_date_next_prev_top import pdnp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              func,
	input  logic [DATE_W-1:0] date_in,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [DATE_W-1:0] date_out
);

	localparam int NSTG = 6;

	logic [NSTG-1:0] valid_q;
	logic [NSTG-1:0] rdy;
	logic [NSTG-1:0] ld;
	logic [NSTG-1:0] vin;
	pdnp_en_t        en;
	pdnp_split_t     split;
	pdnp_ymd_t       ymd;

	// Stage ready chain: a stage takes a beat when empty or draining
	always_comb begin
		rdy[NSTG-1] = !valid_q[NSTG-1] || !out_stall;
		for (int i = NSTG-2; i >= 0; i--) begin
			rdy[i] = !valid_q[i] || rdy[i+1];
		end
	end

	assign vin = {valid_q[NSTG-2:0], in_valid};
	assign ld  = vin & rdy;

	// Advance valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int i = 0; i < NSTG; i++) begin
				if (rdy[i]) begin
					valid_q[i] <= vin[i];
				end
			end
		end
	end

	assign en.s1  = ld[0];
	assign en.s2  = ld[1];
	assign en.s3  = ld[2];
	assign en.s4  = ld[3];
	assign en.s5  = ld[4];
	assign en.out = ld[5];

	assign in_stall  = !rdy[0];
	assign out_valid = valid_q[NSTG-1];

	pdnp_split u_split (
		.clk     (clk),
		.en      (en),
		.func    (func),
		.date_in (date_in),
		.split   (split)
	);

	pdnp_step u_step (
		.clk   (clk),
		.en    (en),
		.split (split),
		.ymd   (ymd)
	);

	pdnp_pack u_pack (
		.clk      (clk),
		.en       (en),
		.ymd      (ymd),
		.date_out (date_out)
	);

endmodule

/* verif/tb.sv */
// Testbench for packed_date_next_prev_top: next-day / previous-day stepping of YYYYMMDD dates.
// Predicts each stepped date in-house and checks results in order under random idling.
// Depends on pdnp_pkg and the RTL of packed_date_next_prev_top.
`timescale 1ns / 1ps

module tb;
	import pdnp_pkg::*;

	localparam int RESET_CYCLES  = 7;
	localparam int HOLD_CYCLES   = 80;
	localparam int ITEMS_PER_SET = 500;
	localparam int TAIL_CYCLES   = 20;
	localparam int CYCLE_LIMIT   = 300000;

	typedef struct {
		logic              dir;
		logic [DATE_W-1:0] date;
	} day_req_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              func = FUNC_NEXT;
	logic [DATE_W-1:0] date_in = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [DATE_W-1:0] date_out;

	day_req_t          date_reqs[$];
	logic [DATE_W-1:0] expected_dates[$];
	day_req_t          next_req;
	logic [DATE_W-1:0] want_date;
	int                tx_idle_pct = 0;
	int                rx_stall_pct = 0;
	bit                long_hold = 1'b0;
	int                hold_cnt = 0;
	int                errors = 0;
	int                cycles = 0;

	packed_date_next_prev_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.date_in   (date_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.date_out  (date_out)
	);

	always #1 clk = ~clk;

	// Month length under the Gregorian leap rule; month zero is empty, above twelve is long
	function automatic bit [31:0] month_days(bit [31:0] yy, bit [31:0] mm);
		bit leap;
		leap = ((yy % 4 == 0) && (yy % 100 != 0)) || (yy % 400 == 0);
		if (mm > 12)
			return 31;
		case (mm)
			0:             return 0;
			2:             return leap ? 29 : 28;
			4, 6, 9, 11:   return 30;
			default:       return 31;
		endcase
	endfunction

	// Step a packed date one day forward or back, wrapping the repacked value to the port width
	function automatic logic [DATE_W-1:0] step_date(logic dir, logic [DATE_W-1:0] packed_in);
		bit [31:0] yy, mm, dd, len, r;
		yy = packed_in / 10000;
		mm = (packed_in % 10000) / 100;
		dd = packed_in % 100;
		if (dir == FUNC_NEXT) begin
			len = month_days(yy, mm);
			dd = dd + 1;
			if (dd > len) begin
				dd = 1;
				mm = mm + 1;
			end
			if (mm == 13) begin
				mm = 1;
				yy = yy + 1;
			end
		end else if ((mm == 1 && dd == 1) || (mm == 0 && dd <= 1)) begin
			yy = yy - 1;
			mm = 12;
			dd = 31;
		end else if (dd > 1) begin
			dd = dd - 1;
		end else begin
			mm = mm - 1;
			dd = month_days(yy, mm);
		end
		r = yy * 10000 + mm * 100 + dd;
		return r[DATE_W-1:0];
	endfunction

	task automatic add_req(logic dir, int unsigned date);
		day_req_t req;
		req.dir = dir;
		req.date = date[DATE_W-1:0];
		date_reqs.push_back(req);
	endtask

	// Mostly well-formed dates, weighted toward month and year ends, plus odd and raw values
	task automatic queue_random(int n);
		int unsigned y, m, d, last, pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			y = $urandom_range(1, 9999);
			m = $urandom_range(1, 12);
			last = month_days(y, m);
			if (pick < 45) begin
				d = $urandom_range(1, last);
			end else if (pick < 75) begin
				if ($urandom_range(1))
					m = $urandom_range(1) ? 12 : 1;
				if ($urandom_range(2) == 0)
					m = 2;
				last = month_days(y, m);
				case ($urandom_range(3))
					0:       d = 1;
					1:       d = last;
					2:       d = (last > 1) ? last - 1 : 1;
					default: d = $urandom_range(1) ? 1 : last;
				endcase
			end else if (pick < 90) begin
				// malformed month or day; year kept off the range limits
				y = $urandom_range(2, 9998);
				case ($urandom_range(2))
					0:       m = 0;
					1:       m = $urandom_range(13, 99);
					default: m = $urandom_range(1, 12);
				endcase
				d = $urandom_range(1) ? $urandom_range(0, 99) : ($urandom_range(1) ? 0 : 1);
			end
			if (pick >= 90)
				add_req(1'($urandom_range(1)), $urandom_range(10101, 99991231));
			else
				add_req(1'($urandom_range(1)), y * 10000 + m * 100 + d);
		end
	endtask

	// Hold the sender until every queued beat has gone in and every result has come back
	task automatic wait_drained();
		while (date_reqs.size() != 0 || in_valid || expected_dates.size() != 0)
			@(posedge clk);
	endtask

	// Drive input beats from the request queue; record the expected date on acceptance
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_dates.push_back(step_date(func, date_in));
			if (!in_valid || !in_stall) begin
				if (date_reqs.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					next_req = date_reqs.pop_front();
					in_valid <= 1'b1;
					func <= next_req.dir;
					date_in <= next_req.date;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Check each accepted result beat against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_dates.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %0d", $time, date_out);
				errors++;
			end else begin
				want_date = expected_dates.pop_front();
				if (date_out !== want_date) begin
					$display("%0t: date_out mismatch, expected %0d, got %0d",
						$time, want_date, date_out);
					errors++;
				end
			end
		end
	end

	// Stall the output at random; once asked, hold off for a long stretch first
	always @(posedge clk) begin
		if (arst_n) begin
			if (long_hold && hold_cnt < HOLD_CYCLES) begin
				out_stall <= 1'b1;
				hold_cnt <= hold_cnt + 1;
			end else begin
				out_stall <= ($urandom_range(99) < rx_stall_pct);
			end
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// directed: range limits, leap rules, month ends, odd months and days
		add_req(FUNC_NEXT, 10101);
		add_req(FUNC_PREV, 10101);
		add_req(FUNC_NEXT, 99991231);
		add_req(FUNC_PREV, 99991231);
		add_req(FUNC_NEXT, 20000228);
		add_req(FUNC_NEXT, 20000229);
		add_req(FUNC_PREV, 20000301);
		add_req(FUNC_NEXT, 19000228);
		add_req(FUNC_PREV, 19000301);
		add_req(FUNC_NEXT, 20231231);
		add_req(FUNC_PREV, 20240101);
		add_req(FUNC_NEXT, 20230430);
		add_req(FUNC_PREV, 20230501);
		add_req(FUNC_NEXT, 20230005);
		add_req(FUNC_PREV, 20230001);
		add_req(FUNC_PREV, 20230000);
		add_req(FUNC_PREV, 20230010);
		add_req(FUNC_NEXT, 20231531);
		add_req(FUNC_NEXT, 20239931);
		add_req(FUNC_PREV, 20231501);
		add_req(FUNC_NEXT, 20230300);
		add_req(FUNC_PREV, 20230300);
		add_req(FUNC_NEXT, 20230245);
		add_req(FUNC_PREV, 20230199);
		add_req(FUNC_PREV, 20230100);
		wait_drained();

		// random sets: no idling with a long output hold-off, then sender idle,
		// receiver stalling, and both
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 0;
					rx_stall_pct = 0;
					long_hold = 1'b1;
				end
				1: begin
					tx_idle_pct = 85;
					rx_stall_pct = 0;
				end
				2: begin
					tx_idle_pct = 0;
					rx_stall_pct = 85;
				end
				default: begin
					tx_idle_pct = 16;
					rx_stall_pct = 16;
				end
			endcase
			queue_random(ITEMS_PER_SET);
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && expected_dates.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* sim.f */
sv/pdnp_pkg.sv
sv/pdnp_split.sv
sv/pdnp_step.sv
sv/pdnp_pack.sv
sv/packed_date_next_prev_top.sv
verif/tb.sv
